// File: sv/dfx_pkg.sv
package dfx_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int BYTE_W = 8;

  // configuration register indexes
  localparam logic [7:0] CFG_ID_MIN  = 8'd0;
  localparam logic [7:0] CFG_ID_MAX  = 8'd1;
  localparam logic [7:0] CFG_MAX_LEN = 8'd2;

  localparam logic [7:0] ID_MIN_RST  = 8'd1;
  localparam logic [7:0] ID_MAX_RST  = 8'd6;
  localparam logic [7:0] MAX_LEN_RST = 8'd64;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CHK  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE  = 2'd0,
    ST_OK          = 2'd1,
    ST_CSUM_ERR    = 2'd2,
    ST_BAD_CHANNEL = 2'd3
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_id;
    logic [7:0] held_length;
    logic [7:0] payload_count;
    logic [7:0] running_xor;
  } chan_state_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } result_t;

  typedef struct packed {
    logic [7:0] id_min;
    logic [7:0] id_max;
    logic [7:0] max_len;
  } cfg_t;

endpackage

// File: sv/dfx_chan_state.sv
module dfx_chan_state #(
  parameter int CHANNELS = dfx_pkg::CHANNELS_DEF,
  parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [CH_W-1:0]     rd_addr,
  input  logic                wr_en,
  input  logic [CH_W-1:0]     wr_addr,
  input  dfx_pkg::chan_state_t wr_data,
  output dfx_pkg::chan_state_t rd_data
);

  dfx_pkg::chan_state_t mem [CHANNELS];
  logic                 vld [CHANNELS];

  dfx_pkg::chan_state_t rd_q;
  dfx_pkg::chan_state_t byp_q;
  logic                 rd_vld_q;
  logic                 byp_hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp_q <= wr_data;
    end
  end

  // write landing on the same edge as the read: forward it
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q  <= 1'b0;
      byp_hit_q <= 1'b0;
    end else if (rd_en) begin
      rd_vld_q  <= vld[rd_addr];
      byp_hit_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    if (byp_hit_q) begin
      rd_data = byp_q;
    end else if (rd_vld_q) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// File: sv/dfx_parse.sv
module dfx_parse (
  input  dfx_pkg::cfg_t        cfg,
  input  dfx_pkg::chan_state_t cur,
  input  logic [7:0]           data_byte,
  input  logic                 bad_channel,
  output dfx_pkg::chan_state_t nxt,
  output logic                 wr_en,
  output dfx_pkg::result_t     res
);

  logic [7:0] count_inc;

  assign count_inc = cur.payload_count + 8'd1;

  always_comb begin
    nxt   = cur;
    res   = '0;
    wr_en = !bad_channel;
    if (bad_channel) begin
      res.status = dfx_pkg::ST_BAD_CHANNEL;
    end else begin
      case (cur.phase)
        dfx_pkg::PH_ID: begin
          if (data_byte >= cfg.id_min && data_byte <= cfg.id_max) begin
            nxt.phase         = dfx_pkg::PH_LEN;
            nxt.held_id       = data_byte;
            nxt.held_length   = 8'd0;
            nxt.payload_count = 8'd0;
            nxt.running_xor   = data_byte;
          end else begin
            nxt = '0;
          end
        end
        dfx_pkg::PH_LEN: begin
          if (data_byte <= cfg.max_len) begin
            nxt.held_length   = data_byte;
            nxt.running_xor   = cur.running_xor ^ data_byte;
            nxt.payload_count = 8'd0;
            nxt.phase         = (data_byte == 8'd0) ? dfx_pkg::PH_CHK : dfx_pkg::PH_DATA;
          end else begin
            nxt = '0;
          end
        end
        dfx_pkg::PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = data_byte;
          res.payload_index = cur.payload_count;
          nxt.running_xor   = cur.running_xor ^ data_byte;
          nxt.payload_count = count_inc;
          if (count_inc >= cur.held_length) begin
            nxt.phase = dfx_pkg::PH_CHK;
          end
        end
        dfx_pkg::PH_CHK: begin
          res.status       = (cur.running_xor == data_byte) ? dfx_pkg::ST_OK
                                                             : dfx_pkg::ST_CSUM_ERR;
          res.frame_id     = cur.held_id;
          res.frame_length = cur.held_length;
          nxt              = '0;
        end
        default: begin
          nxt = '0;
        end
      endcase
    end
  end

endmodule

// File: sv/multichannel_frame_deframer_xor.sv
// Multichannel deframer for id / length / payload / XOR-checksum frames. Takes one
// byte beat per clock while s_tready is high (s_tuser = channel, s_tdata = byte)
// and returns exactly one result beat per input beat: an input register feeds
// combinational parse logic into the result register. Per-channel
// parser state lives in a CHANNELS-entry array read as the beat is accepted; a beat
// on the same channel as the one just ahead of it gets that beat's update forwarded,
// so back-to-back bytes on one channel run at full rate. Per-entry valid bits give
// the reset state at once, with no clearing pass. Configuration (cfg_index 0 id_min,
// 1 id_max, 2 max_payload_length; other indexes ignored) is taken every cycle and is
// meant to be written only while the block is idle.
module multichannel_frame_deframer_xor #(
  parameter int CHANNELS = dfx_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [7:0]  s_tuser,   // [7:0] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] frame_id, [15:8] frame_length,
                                 // [23:16] payload_byte, [31:24] payload_index
  output logic [2:0]  m_tuser,   // [1:0] status, [2] payload_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dfx_pkg::cfg_t cfg;

  logic            s1_valid;
  logic            s1_bad;
  logic [CH_W-1:0] s1_ch;
  logic [7:0]      s1_byte;
  logic            s1_adv;
  logic            accept;
  logic            bad_in;

  dfx_pkg::chan_state_t cur_state;
  dfx_pkg::chan_state_t nxt_state;
  logic                 upd_en;
  dfx_pkg::result_t     res;
  dfx_pkg::result_t     res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_min  <= dfx_pkg::ID_MIN_RST;
      cfg.id_max  <= dfx_pkg::ID_MAX_RST;
      cfg.max_len <= dfx_pkg::MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfx_pkg::CFG_ID_MIN:  cfg.id_min  <= cfg_data;
        dfx_pkg::CFG_ID_MAX:  cfg.id_max  <= cfg_data;
        dfx_pkg::CFG_MAX_LEN: cfg.max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign bad_in   = {1'b0, s_tuser} >= 9'(CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bad  <= bad_in;
      s1_ch   <= s_tuser[CH_W-1:0];
      s1_byte <= s_tdata;
    end
  end

  dfx_chan_state #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && !bad_in),
    .rd_addr (s_tuser[CH_W-1:0]),
    .wr_en   (s1_adv && upd_en),
    .wr_addr (s1_ch),
    .wr_data (nxt_state),
    .rd_data (cur_state)
  );

  dfx_parse u_parse (
    .cfg         (cfg),
    .cur         (cur_state),
    .data_byte   (s1_byte),
    .bad_channel (s1_bad),
    .nxt         (nxt_state),
    .wr_en       (upd_en),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.payload_index, res_q.payload_byte,
                    res_q.frame_length, res_q.frame_id};
  assign m_tuser = {res_q.payload_valid, res_q.status};

  // an empty result register never blocks the input side
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a beat held in the input register stays put until it moves on
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_ch) && $stable(s1_byte)))
    else $error("input register lost a stalled beat");

  // bad-channel result carries nothing else
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == dfx_pkg::ST_BAD_CHANNEL) |-> (m_tdata == 32'd0 && !m_tuser[2]))
    else $error("bad-channel result with payload fields set");

  // payload beats never report a frame end
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == dfx_pkg::ST_INCOMPLETE
                                  && m_tdata[15:0] == 16'd0))
    else $error("payload beat with frame status");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dfx_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int NPHASES = 6;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [7:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Per-channel parser shadow plus the queue of results still owed by the block.
  class frame_scoreboard;
    logic [7:0] id_lo;
    logic [7:0] id_hi;
    logic [7:0] len_max;
    phase_t     ph [NCH];
    logic [7:0] f_id [NCH];
    logic [7:0] f_len [NCH];
    logic [7:0] f_cnt [NCH];
    logic [7:0] f_xor [NCH];
    result_t    expected_q [$];
    int         errors;
    int         n_in;
    int         n_ok;
    int         n_csum;
    int         n_badch;
    int         n_payload;

    function new();
      id_lo = ID_MIN_RST;
      id_hi = ID_MAX_RST;
      len_max = MAX_LEN_RST;
      for (int c = 0; c < NCH; c++) idle_chan(c);
    endfunction

    function void idle_chan(int c);
      ph[c] = PH_ID;
      f_id[c] = '0;
      f_len[c] = '0;
      f_cnt[c] = '0;
      f_xor[c] = '0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        CFG_ID_MIN:  id_lo = val;
        CFG_ID_MAX:  id_hi = val;
        CFG_MAX_LEN: len_max = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] ch, logic [7:0] b);
      result_t r;
      int c;
      r = '0;
      n_in++;
      if (ch >= NCH) begin
        r.status = ST_BAD_CHANNEL;
        n_badch++;
      end else begin
        c = ch;
        case (ph[c])
          PH_ID: begin
            if (b >= id_lo && b <= id_hi) begin
              f_id[c] = b;
              f_len[c] = '0;
              f_cnt[c] = '0;
              f_xor[c] = b;
              ph[c] = PH_LEN;
            end else begin
              idle_chan(c);
            end
          end
          PH_LEN: begin
            if (b <= len_max) begin
              f_len[c] = b;
              f_xor[c] = f_xor[c] ^ b;
              f_cnt[c] = '0;
              ph[c] = (b == 8'd0) ? PH_CHK : PH_DATA;
            end else begin
              idle_chan(c);
            end
          end
          PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = f_cnt[c];
            f_xor[c] = f_xor[c] ^ b;
            f_cnt[c] = f_cnt[c] + 8'd1;
            if (f_cnt[c] >= f_len[c]) ph[c] = PH_CHK;
            n_payload++;
          end
          default: begin
            r.status = (f_xor[c] == b) ? ST_OK : ST_CSUM_ERR;
            r.frame_id = f_id[c];
            r.frame_length = f_len[c];
            if (r.status == ST_OK) n_ok++;
            else n_csum++;
            idle_chan(c);
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(logic [31:0] td, logic [2:0] tu);
      result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result beat tdata=%h tuser=%h", td, tu));
        return;
      end
      e = expected_q.pop_front();
      if (tu[1:0] !== e.status)
        report($sformatf("status exp %0d got %0d", e.status, tu[1:0]));
      if (tu[2] !== e.payload_valid)
        report($sformatf("payload_valid exp %0d got %0d", e.payload_valid, tu[2]));
      if (td[7:0] !== e.frame_id)
        report($sformatf("frame_id exp %h got %h", e.frame_id, td[7:0]));
      if (td[15:8] !== e.frame_length)
        report($sformatf("frame_length exp %h got %h", e.frame_length, td[15:8]));
      if (td[23:16] !== e.payload_byte)
        report($sformatf("payload_byte exp %h got %h", e.payload_byte, td[23:16]));
      if (td[31:24] !== e.payload_index)
        report($sformatf("payload_index exp %h got %h", e.payload_index, td[31:24]));
    endtask
  endclass

  frame_scoreboard sb = new();

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  rx_hold;
  event hold_ev;

  // frame under construction per channel, fed out one byte at a time
  logic [7:0] fbuf [NCH][260];
  int         fpos [NCH];
  int         ftot [NCH];

  multichannel_frame_deframer_xor #(
    .CHANNELS(NCH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready = !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
  end

  // long output stall; sender keeps pushing so the pipeline backs up
  initial begin
    forever begin
      @(hold_ev);
      rx_hold = 1'b1;
      repeat (300) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  initial begin
    #400us;
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] ch, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = ch;
    s_tdata = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(ch, b);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void build_frame(int c, bit full_len);
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] x;
    int         hi;
    int         r;
    if (sb.id_lo <= sb.id_hi && $urandom_range(99) < 90)
      id = 8'($urandom_range(sb.id_hi, sb.id_lo));
    else
      id = 8'($urandom);
    hi = (sb.len_max < 12) ? sb.len_max : 12;
    r = $urandom_range(99);
    if (full_len) len = sb.len_max;
    else if (r < 85) len = 8'($urandom_range(hi, 0));
    else if (r < 93) len = 8'($urandom_range(sb.len_max, 0));
    else len = 8'($urandom);
    fbuf[c][0] = id;
    fbuf[c][1] = len;
    fpos[c] = 0;
    if (len > sb.len_max) begin
      // header gets dropped; stop there and let the channel resync
      ftot[c] = 2;
      return;
    end
    x = id ^ len;
    for (int i = 0; i < len; i++) begin
      fbuf[c][2 + i] = 8'($urandom);
      x = x ^ fbuf[c][2 + i];
    end
    if ($urandom_range(99) < 15) x = x ^ 8'($urandom_range(255, 1));
    fbuf[c][2 + len] = x;
    ftot[c] = 3 + len;
  endfunction

  task automatic send_random();
    logic [7:0] ch;
    int         c;
    if ($urandom_range(99) < 8) begin
      // noise: bad channel or a stray byte breaking a frame
      if ($urandom_range(1) == 1) ch = 8'($urandom_range(255, NCH));
      else ch = 8'($urandom_range(NCH - 1, 0));
      send_byte(ch, 8'($urandom));
    end else begin
      c = $urandom_range(NCH - 1, 0);
      if (fpos[c] >= ftot[c]) build_frame(c, 1'b0);
      send_byte(8'(c), fbuf[c][fpos[c]]);
      fpos[c]++;
    end
  endtask

  logic [7:0] ph_id_lo [NPHASES] = '{8'd1, 8'd0, 8'd255, 8'd200, 8'd10, 8'd0};
  logic [7:0] ph_id_hi [NPHASES] = '{8'd6, 8'd255, 8'd255, 8'd100, 8'd20, 8'd0};
  logic [7:0] ph_len   [NPHASES] = '{8'd64, 8'd255, 8'd0, 8'd10, 8'd5, 8'd255};
  int         ph_items [NPHASES] = '{250, 200, 150, 100, 250, 250};

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_hold = 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 72;
    for (int c = 0; c < NCH; c++) begin
      fpos[c] = 0;
      ftot[c] = 0;
    end
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: bad channels, rejected id, oversize length, zero length,
    // payload extremes, bad checksum, interleaved channels
    send_byte(8'd8, 8'h01);
    send_byte(8'd255, 8'hFF);
    send_byte(8'd0, 8'h00);
    send_byte(8'd0, 8'h07);
    send_byte(8'd1, 8'h01);
    send_byte(8'd1, 8'd65);
    send_byte(8'd2, 8'h06);
    send_byte(8'd2, 8'h00);
    send_byte(8'd2, 8'h06);
    send_byte(8'd3, 8'h03);
    send_byte(8'd3, 8'h02);
    send_byte(8'd3, 8'h00);
    send_byte(8'd3, 8'hFF);
    send_byte(8'd3, 8'hFE);
    send_byte(8'd7, 8'h01);
    send_byte(8'd7, 8'h01);
    send_byte(8'd7, 8'hAA);
    send_byte(8'd7, 8'h55);
    send_byte(8'd4, 8'h02);
    send_byte(8'd5, 8'h04);
    send_byte(8'd4, 8'h00);
    send_byte(8'd5, 8'h00);
    send_byte(8'd4, 8'h02);
    send_byte(8'd5, 8'h05);
    drain_results();

    for (int p = 0; p < NPHASES; p++) begin
      if (p > 0) begin
        write_reg(CFG_ID_MIN, ph_id_lo[p]);
        write_reg(CFG_ID_MAX, ph_id_hi[p]);
        write_reg(CFG_MAX_LEN, ph_len[p]);
      end
      if (p == 3) begin
        // unmapped indexes must not disturb anything
        write_reg(8'd3, 8'($urandom));
        write_reg(8'hFF, 8'($urandom));
      end
      case (p / 2)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (sb.id_lo <= sb.id_hi) build_frame(0, 1'b1);
      if (p == 4) -> hold_ev;
      for (int i = 0; i < ph_items[p]; i++) send_random();
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d input beats over %0d register settings: %0d good frames,",
             sb.n_in, NPHASES, sb.n_ok);
    $display("  %0d checksum errors, %0d bad-channel beats, %0d payload beats",
             sb.n_csum, sb.n_badch, sb.n_payload);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: multichannel_frame_deframer_xor.f
sv/dfx_pkg.sv
sv/dfx_chan_state.sv
sv/dfx_parse.sv
sv/multichannel_frame_deframer_xor.sv
tb/tb_top.sv
